// File: rtl/core/tcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcd_pkg;

  localparam int CoefBits = 32;
  localparam int FieldBits = 12;
  localparam int CoordBits = 16;
  localparam int AddrBits = 5;
  localparam int DataBits = 32;

  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_UP = 2'd2;

  localparam logic [2:0] REG_COEF_XX = 3'd0;
  localparam logic [2:0] REG_COEF_XY = 3'd1;
  localparam logic [2:0] REG_OFFSET_X = 3'd2;
  localparam logic [2:0] REG_COEF_YX = 3'd3;
  localparam logic [2:0] REG_COEF_YY = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y = 3'd5;
  localparam logic [2:0] REG_PRESS_THR = 3'd6;
  localparam logic [2:0] REG_RELEASE_THR = 3'd7;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_MOVE,
    MODE_DOWN_MOVE,
    MODE_MOVE_UP
  } mode_t;

  typedef struct packed {
    logic signed [CoefBits-1:0] coef_xx;
    logic signed [CoefBits-1:0] coef_xy;
    logic signed [CoefBits-1:0] offset_x;
    logic signed [CoefBits-1:0] coef_yx;
    logic signed [CoefBits-1:0] coef_yy;
    logic signed [CoefBits-1:0] offset_y;
    logic [FieldBits-1:0] press_threshold;
    logic [FieldBits-1:0] release_threshold;
  } cfg_t;

  typedef struct packed {
    logic load;
    mode_t mode;
  } evq_req_t;

endpackage

`default_nettype wire

// File: rtl/core/tcd_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tcd_regs
  import tcd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic      [DataBits-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  logic       wr_en;
  logic [2:0] index;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign index = paddr[AddrBits-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_xx <= 32'sd65536;
      cfg.coef_xy <= '0;
      cfg.offset_x <= '0;
      cfg.coef_yx <= '0;
      cfg.coef_yy <= 32'sd65536;
      cfg.offset_y <= '0;
      cfg.press_threshold <= 12'd400;
      cfg.release_threshold <= 12'd250;
    end else if (wr_en) begin
      case (index)
        REG_COEF_XX: cfg.coef_xx <= pwdata;
        REG_COEF_XY: cfg.coef_xy <= pwdata;
        REG_OFFSET_X: cfg.offset_x <= pwdata;
        REG_COEF_YX: cfg.coef_yx <= pwdata;
        REG_COEF_YY: cfg.coef_yy <= pwdata;
        REG_OFFSET_Y: cfg.offset_y <= pwdata;
        REG_PRESS_THR: cfg.press_threshold <= pwdata[FieldBits-1:0];
        REG_RELEASE_THR: cfg.release_threshold <= pwdata[FieldBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_COEF_XX: prdata = cfg.coef_xx;
      REG_COEF_XY: prdata = cfg.coef_xy;
      REG_OFFSET_X: prdata = cfg.offset_x;
      REG_COEF_YX: prdata = cfg.coef_yx;
      REG_COEF_YY: prdata = cfg.coef_yy;
      REG_OFFSET_Y: prdata = cfg.offset_y;
      REG_PRESS_THR: prdata = {{(DataBits-FieldBits){1'b0}}, cfg.press_threshold};
      REG_RELEASE_THR: prdata = {{(DataBits-FieldBits){1'b0}}, cfg.release_threshold};
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/tcd_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module tcd_axis
  import tcd_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic        [FieldBits-1:0] raw_a,
  input  wire logic        [FieldBits-1:0] raw_b,
  input  wire logic signed [CoefBits-1:0]  coef_a,
  input  wire logic signed [CoefBits-1:0]  coef_b,
  input  wire logic signed [CoefBits-1:0]  offset,
  output logic signed      [CoordBits-1:0] coord
);

  localparam int ProdBits = CoefBits + FieldBits + 1;
  localparam int SumBits = ProdBits + 2;
  localparam int QuotBits = SumBits - 16;

  logic signed [ProdBits-1:0] prod_a;
  logic signed [ProdBits-1:0] prod_b;
  logic signed [SumBits-1:0]  sum;
  logic signed [QuotBits-1:0] quot;

  // product register
  always_ff @(posedge clk) begin
    if (load) begin
      prod_a <= ProdBits'(coef_a) * ProdBits'($signed({1'b0, raw_a}));
      prod_b <= ProdBits'(coef_b) * ProdBits'($signed({1'b0, raw_b}));
    end
  end

  // floor by dropping the fraction, then saturate
  always_comb begin
    sum = SumBits'(prod_a) + SumBits'(prod_b) + SumBits'(offset);
    quot = sum[SumBits-1:16];
    if (quot > QuotBits'(32767)) begin
      coord = 16'sh7fff;
    end else if (quot < -QuotBits'(32768)) begin
      coord = -16'sh8000;
    end else begin
      coord = quot[CoordBits-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tcd_evq.sv
`timescale 1ns / 1ps
`default_nettype none

module tcd_evq
  import tcd_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  evq_req_t                         req,
  input  wire logic signed [CoordBits-1:0] sx,
  input  wire logic signed [CoordBits-1:0] sy,
  output logic                             free,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic             [1:0]           event_kind,
  output logic signed      [CoordBits-1:0] screen_x,
  output logic signed      [CoordBits-1:0] screen_y,
  output logic                             last_of_run
);

  mode_t mode;
  logic  phase;
  logic  take;

  assign take = out_valid && out_ready;
  assign last_of_run = (mode == MODE_MOVE) || phase;
  assign free = !out_valid || (take && last_of_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase <= 1'b0;
      mode <= MODE_NONE;
    end else if (req.load) begin
      out_valid <= 1'b1;
      phase <= 1'b0;
      mode <= req.mode;
    end else if (take) begin
      if (last_of_run) begin
        out_valid <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      screen_x <= sx;
      screen_y <= sy;
    end
  end

  always_comb begin
    case (mode)
      MODE_DOWN_MOVE: event_kind = phase ? KIND_MOVE : KIND_DOWN;
      MODE_MOVE_UP: event_kind = phase ? KIND_UP : KIND_MOVE;
      default: event_kind = KIND_MOVE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/touch_calibrate_and_detect.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps raw touch samples to screen coordinates with a Q16.16 affine transform
// (floor, saturated to 16-bit signed) and tracks pen up/down with pressure
// hysteresis. A sample passes an input register, a product register and an
// output register, in that order, before its first event appears. A sample
// that gives one move event, or puts the pen down or releases it and so gives
// two events, holds the output register until its last event is taken; a
// sample with the pen staying up gives no event. The output register can load
// the next sample as the last event of the current one is taken; out_ready
// back-pressure stalls the pipeline. Coefficients and thresholds sit in an
// APB register file at byte addresses 0 to 28.
module touch_calibrate_and_detect
  import tcd_pkg::*;
#(
  parameter int RAW_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic        [AddrBits-1:0]  paddr,
  input  wire logic        [DataBits-1:0]  pwdata,
  output logic             [DataBits-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic        [FieldBits-1:0] raw_x,
  input  wire logic        [FieldBits-1:0] raw_y,
  input  wire logic        [FieldBits-1:0] raw_pressure,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic             [1:0]           event_kind,
  output logic signed      [CoordBits-1:0] screen_x,
  output logic signed      [CoordBits-1:0] screen_y,
  output logic                             last_of_run
);

  localparam int UseBits = (RAW_BITS < FieldBits) ? RAW_BITS : FieldBits;
  localparam logic [FieldBits-1:0] RawMask = FieldBits'((64'd1 << UseBits) - 64'd1);

  cfg_t                   cfg;
  logic                   a_valid;
  logic [FieldBits-1:0]   a_x;
  logic [FieldBits-1:0]   a_y;
  logic [FieldBits-1:0]   a_p;
  logic                   a_go;
  logic                   b_valid;
  mode_t                  b_mode;
  logic                   b_go;
  logic                   b_free;
  logic                   pen_down;
  logic                   pen_down_next;
  mode_t                  mode_next;
  logic                   evq_free;
  evq_req_t               evq_req;
  logic signed [CoordBits-1:0] sx;
  logic signed [CoordBits-1:0] sy;

  tcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // flow control
  assign b_go = b_valid && ((b_mode == MODE_NONE) || evq_free);
  assign b_free = !b_valid || b_go;
  assign a_go = a_valid && b_free;
  assign in_ready = !a_valid || a_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_x <= raw_x & RawMask;
      a_y <= raw_y & RawMask;
      a_p <= raw_pressure & RawMask;
    end
  end

  // pen hysteresis
  always_comb begin
    pen_down_next = pen_down;
    if (!pen_down) begin
      if (a_p > cfg.press_threshold) begin
        mode_next = MODE_DOWN_MOVE;
        pen_down_next = 1'b1;
      end else begin
        mode_next = MODE_NONE;
      end
    end else if (a_p < cfg.release_threshold) begin
      mode_next = MODE_MOVE_UP;
      pen_down_next = 1'b0;
    end else begin
      mode_next = MODE_MOVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_down <= 1'b0;
      b_valid <= 1'b0;
      b_mode <= MODE_NONE;
    end else begin
      if (a_go) begin
        pen_down <= pen_down_next;
        b_mode <= mode_next;
      end
      if (b_free) begin
        b_valid <= a_go;
      end
    end
  end

  tcd_axis u_axis_x (
    .clk    (clk),
    .load   (a_go),
    .raw_a  (a_x),
    .raw_b  (a_y),
    .coef_a (cfg.coef_xx),
    .coef_b (cfg.coef_xy),
    .offset (cfg.offset_x),
    .coord  (sx)
  );

  tcd_axis u_axis_y (
    .clk    (clk),
    .load   (a_go),
    .raw_a  (a_x),
    .raw_b  (a_y),
    .coef_a (cfg.coef_yx),
    .coef_b (cfg.coef_yy),
    .offset (cfg.offset_y),
    .coord  (sy)
  );

  assign evq_req.load = b_go && (b_mode != MODE_NONE);
  assign evq_req.mode = b_mode;

  tcd_evq u_evq (
    .clk         (clk),
    .rst         (rst),
    .req         (evq_req),
    .sx          (sx),
    .sy          (sy),
    .free        (evq_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .screen_x    (screen_x),
    .screen_y    (screen_y),
    .last_of_run (last_of_run)
  );

  a_press_sets_pen: assert property (@(posedge clk) disable iff (rst)
    a_go && !pen_down && (a_p > cfg.press_threshold) |=> pen_down)
    else $error("pen not set after press");

  a_up_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_UP) |-> last_of_run)
    else $error("up event not last of run");

  a_down_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_DOWN) |-> !last_of_run)
    else $error("down event marked last");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_kind == KIND_DOWN) || (event_kind == KIND_MOVE)
      || (event_kind == KIND_UP))
    else $error("illegal event kind");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !pen_down)
    else $error("not idle after reset");

endmodule

`default_nettype wire
